// ----- rtl/dg3v_pkg.sv -----
`default_nettype none
// ============================================================================
// dg3v_pkg - shared definitions for the 3D double-gyre velocity block
// Fixed-point helpers, register indexes, constants and the arctangent table.
// ============================================================================
package dg3v_pkg;

   // Default values of the top-level parameters
   localparam int FRAC_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF = 18;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGULAR_FREQ  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERTURBATION  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEADY_ENABLE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEADY_TIME   = 3'd4;

   // Register reset values
   localparam logic signed [31:0] AMPLITUDE_RST    = 32'sd6554;
   localparam logic signed [31:0] ANGULAR_FREQ_RST = 32'sd41175;
   localparam logic signed [31:0] PERTURBATION_RST = 32'sd16384;
   localparam logic signed [31:0] STEADY_TIME_RST  = 32'sd0;

   // Constants held with 30 fraction bits (TURNS_PER_RAD with 32)
   localparam longint Q30_PI         = 64'sd3373259426;
   localparam longint Q30_INV_PI     = 64'sd341782638;
   localparam longint Q30_INV_GAIN   = 64'sd652032874;
   localparam longint TURNS_PER_RAD  = 64'sd683565276;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   // Saturate a 66-bit value to 32 bits signed
   function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'(SAT_MAX)) begin
         r = 32'sh7fff_ffff;
      end else if (v < 66'(SAT_MIN)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Product of two 32-bit values, exact
   function automatic logic signed [65:0] mul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return 66'(p);
   endfunction

   // Round half up by frac bits, then saturate
   function automatic logic signed [31:0] qround(input logic signed [65:0] p,
                                                 input int unsigned frac);
      logic signed [65:0] r;
      r = (p + (66'sd1 <<< (frac - 1))) >>> frac;
      return sat66(r);
   endfunction

   // Saturating sum and difference
   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat66(66'(a) + 66'(b));
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat66(66'(a) - 66'(b));
   endfunction

   // Arctangent of 2^-i in turns, 32 fraction bits
   function automatic logic [31:0] atan_turns(input int unsigned idx);
      logic [31:0] r;
      case (idx)
         0:       r = 32'h2000_0000;
         1:       r = 32'h12E4_051E;
         2:       r = 32'h09FB_385B;
         3:       r = 32'h0511_11D4;
         4:       r = 32'h028B_0D43;
         5:       r = 32'h0145_D7E1;
         6:       r = 32'h00A2_F61E;
         7:       r = 32'h0051_7C55;
         8:       r = 32'h0028_BE53;
         9:       r = 32'h0014_5F2F;
         10:      r = 32'h000A_2F98;
         11:      r = 32'h0005_17CC;
         12:      r = 32'h0002_8BE6;
         13:      r = 32'h0001_45F3;
         14:      r = 32'h0000_A2FA;
         15:      r = 32'h0000_517D;
         16:      r = 32'h0000_28BE;
         17:      r = 32'h0000_145F;
         18:      r = 32'h0000_0A30;
         19:      r = 32'h0000_0518;
         20:      r = 32'h0000_028C;
         21:      r = 32'h0000_0146;
         22:      r = 32'h0000_00A3;
         23:      r = 32'h0000_0051;
         24:      r = 32'h0000_0029;
         25:      r = 32'h0000_0014;
         26:      r = 32'h0000_000A;
         27:      r = 32'h0000_0005;
         28:      r = 32'h0000_0003;
         29:      r = 32'h0000_0001;
         30:      r = 32'h0000_0001;
         default: r = 32'h0000_0000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/double_gyre_3d_velocity.sv -----
`default_nettype none
// ============================================================================
// double_gyre_3d_velocity - velocity of the time-dependent 3D double gyre
// Signed fixed-point sample point in, velocity vector out.
// ============================================================================
// Usage:
//   req_* carries one sample point (time, x, y, z) per beat, rsp_* one
//   velocity (vel_x, vel_y, vel_z) per beat, both valid/ready.
//   csr_* writes amplitude, angular frequency, perturbation, steady mode
//   and steady time; write only while the pipeline is empty.
//   The data path is two CORDIC passes in series (time angle, then
//   position angles) with the multiply/round stages around them.
//   Throughput is one point per cycle unless rsp_ready holds the pipeline; every multiply has its own stage.
//   Reset clears the pipeline valid bits and loads the register defaults.
//   When rsp_ready is low with a result waiting, the whole pipeline holds
//   and req_ready drops; nothing is lost or repeated.
// ============================================================================
module double_gyre_3d_velocity #(
   parameter int FRAC_BITS     = dg3v_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = dg3v_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [31:0]                   req_time_in,
   input  wire logic signed [31:0]                   req_pos_x,
   input  wire logic signed [31:0]                   req_pos_y,
   input  wire logic signed [31:0]                   req_pos_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [31:0]                        rsp_vel_x,
   output logic signed [31:0]                        rsp_vel_y,
   output logic signed [31:0]                        rsp_vel_z,
   input  wire logic                                 csr_we,
   input  wire logic [dg3v_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [31:0]                          csr_wdata
);
   import dg3v_pkg::*;

   localparam int     CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int     DEPTH      = 18 + 2 * CORDIC_LAT;
   localparam int     SH         = 30 - FRAC_BITS;
   localparam longint RND30      = (SH == 0) ? 0 :
                                   (longint'(1) << ((SH > 0) ? SH - 1 : 0));
   localparam logic signed [33:0] PI_Q     = 34'((Q30_PI + RND30) >>> SH);
   localparam logic signed [31:0] INV_PI_Q = 32'((Q30_INV_PI + RND30) >>> SH);
   localparam logic signed [31:0] ONE      = 32'(longint'(1) << FRAC_BITS);
   localparam logic signed [31:0] HALF     = 32'(longint'(1) << (FRAC_BITS - 1));
   localparam logic signed [31:0] TURNS_Q  = 32'(TURNS_PER_RAD);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } sb1_type;

   typedef struct packed {
      logic signed [31:0] g;
      logic signed [31:0] z;
      logic signed [31:0] e2;
   } sb2_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [31:0] amplitude_ff;
   logic signed [31:0] angular_freq_ff;
   logic signed [31:0] perturbation_ff;
   logic               steady_enable_ff;
   logic signed [31:0] steady_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff     <= AMPLITUDE_RST;
         angular_freq_ff  <= ANGULAR_FREQ_RST;
         perturbation_ff  <= PERTURBATION_RST;
         steady_enable_ff <= 1'b0;
         steady_time_ff   <= STEADY_TIME_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AMPLITUDE:     amplitude_ff     <= signed'(csr_wdata);
            CSR_ANGULAR_FREQ:  angular_freq_ff  <= signed'(csr_wdata);
            CSR_PERTURBATION:  perturbation_ff  <= signed'(csr_wdata);
            CSR_STEADY_ENABLE: steady_enable_ff <= csr_wdata[0];
            CSR_STEADY_TIME:   steady_time_ff   <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Derived coefficients pi*A and omega/pi, refreshed every cycle
   logic signed [65:0] pa_prod_ff;
   logic signed [65:0] w_prod_ff;
   logic signed [31:0] pa_ff;
   logic signed [31:0] w_ff;

   always_ff @(posedge clock) begin
      pa_prod_ff <= 66'(PI_Q) * 66'(amplitude_ff);
      w_prod_ff  <= mul32(angular_freq_ff, INV_PI_Q);
      pa_ff      <= qround(pa_prod_ff, FRAC_BITS);
      w_ff       <= qround(w_prod_ff, FRAC_BITS);
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage advances together
   // ------------------------------------------------------------------
   logic             adv;
   logic [DEPTH-1:0] vld_ff;

   assign adv       = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------
   // Front: time angle and its phase in turns
   // ------------------------------------------------------------------
   logic signed [31:0] t_sel;
   logic signed [65:0] p1_theta_ff;
   sb1_type            p1_pos_ff, p2_pos_ff, p3_pos_ff, p4_pos_ff;
   logic signed [31:0] p2_theta_ff;
   logic signed [65:0] p3_turn_ff;
   logic        [31:0] p4_ph_ff;

   assign t_sel = steady_enable_ff ? steady_time_ff : req_time_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_theta_ff <= mul32(angular_freq_ff, t_sel);
         p1_pos_ff   <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
         p2_theta_ff <= qround(p1_theta_ff, FRAC_BITS);
         p2_pos_ff   <= p1_pos_ff;
         p3_turn_ff  <= mul32(p2_theta_ff, TURNS_Q);
         p3_pos_ff   <= p2_pos_ff;
         p4_ph_ff    <= p3_turn_ff[FRAC_BITS +: 32];
         p4_pos_ff   <= p3_pos_ff;
      end
   end

   // ------------------------------------------------------------------
   // First CORDIC pass: sin(wt) and sin(2wt)
   // ------------------------------------------------------------------
   logic signed [31:0] s1, c1, s2, c2;
   logic        [31:0] ph2;
   sb1_type            sb1_ff [CORDIC_LAT];

   assign ph2 = {p4_ph_ff[30:0], 1'b0};

   dg3v_sincos #(.FRAC_BITS(FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_wt (
      .clock(clock), .en(adv), .phase(p4_ph_ff), .sin_q(s1), .cos_q(c1)
   );

   dg3v_sincos #(.FRAC_BITS(FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_2wt (
      .clock(clock), .en(adv), .phase(ph2), .sin_q(s2), .cos_q(c2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sb1_ff[0] <= p4_pos_ff;
         for (int i = 1; i < CORDIC_LAT; i++) begin
            sb1_ff[i] <= sb1_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Middle: a, b, f and the y-velocity factor g
   // ------------------------------------------------------------------
   sb1_type            q1_pos_ff, q2_pos_ff, q3_pos_ff, q4_pos_ff;
   logic signed [65:0] q1_pe1_ff, q1_pe2_ff;
   logic signed [31:0] q2_a_ff, q2_e2_ff;
   logic signed [31:0] q3_two_ff, q3_e2_ff;
   logic signed [65:0] q3_pax_ff;
   logic signed [31:0] q4_b_ff, q4_ax_ff, q4_two_ff, q4_e2_ff;
   logic signed [65:0] q5_paxx_ff, q5_pbx_ff, q5_ptx_ff;
   logic signed [31:0] q5_b_ff, q5_y_ff, q5_z_ff, q5_e2_ff;
   logic signed [31:0] q6_axx_ff, q6_bx_ff, q6_tx_ff;
   logic signed [31:0] q6_b_ff, q6_y_ff, q6_z_ff, q6_e2_ff;
   logic signed [31:0] q7_f_ff, q7_g_ff, q7_y_ff, q7_z_ff, q7_e2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_pe1_ff  <= mul32(perturbation_ff, s1);
         q1_pe2_ff  <= mul32(perturbation_ff, s2);
         q1_pos_ff  <= sb1_ff[CORDIC_LAT-1];

         q2_a_ff    <= qround(q1_pe1_ff, FRAC_BITS);
         q2_e2_ff   <= qround(q1_pe2_ff, FRAC_BITS);
         q2_pos_ff  <= q1_pos_ff;

         q3_two_ff  <= add_sat(q2_a_ff, q2_a_ff);
         q3_pax_ff  <= mul32(q2_a_ff, q2_pos_ff.x);
         q3_e2_ff   <= q2_e2_ff;
         q3_pos_ff  <= q2_pos_ff;

         q4_b_ff    <= sub_sat(ONE, q3_two_ff);
         q4_ax_ff   <= qround(q3_pax_ff, FRAC_BITS);
         q4_two_ff  <= q3_two_ff;
         q4_e2_ff   <= q3_e2_ff;
         q4_pos_ff  <= q3_pos_ff;

         q5_paxx_ff <= mul32(q4_ax_ff, q4_pos_ff.x);
         q5_pbx_ff  <= mul32(q4_b_ff, q4_pos_ff.x);
         q5_ptx_ff  <= mul32(q4_two_ff, q4_pos_ff.x);
         q5_b_ff    <= q4_b_ff;
         q5_y_ff    <= q4_pos_ff.y;
         q5_z_ff    <= q4_pos_ff.z;
         q5_e2_ff   <= q4_e2_ff;

         q6_axx_ff  <= qround(q5_paxx_ff, FRAC_BITS);
         q6_bx_ff   <= qround(q5_pbx_ff, FRAC_BITS);
         q6_tx_ff   <= qround(q5_ptx_ff, FRAC_BITS);
         q6_b_ff    <= q5_b_ff;
         q6_y_ff    <= q5_y_ff;
         q6_z_ff    <= q5_z_ff;
         q6_e2_ff   <= q5_e2_ff;

         q7_f_ff    <= add_sat(q6_axx_ff, q6_bx_ff);
         q7_g_ff    <= add_sat(q6_tx_ff, q6_b_ff);
         q7_y_ff    <= q6_y_ff;
         q7_z_ff    <= q6_z_ff;
         q7_e2_ff   <= q6_e2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Second CORDIC pass: pi*f and pi*y
   // ------------------------------------------------------------------
   logic        [31:0] ph_f, ph_y;
   logic signed [31:0] sf, cf, sy, cy;
   sb2_type            sb2_ff [CORDIC_LAT];

   assign ph_f = 32'(q7_f_ff) << (31 - FRAC_BITS);
   assign ph_y = 32'(q7_y_ff) << (31 - FRAC_BITS);

   dg3v_sincos #(.FRAC_BITS(FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_f (
      .clock(clock), .en(adv), .phase(ph_f), .sin_q(sf), .cos_q(cf)
   );

   dg3v_sincos #(.FRAC_BITS(FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_y (
      .clock(clock), .en(adv), .phase(ph_y), .sin_q(sy), .cos_q(cy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sb2_ff[0] <= '{g: q7_g_ff, z: q7_z_ff, e2: q7_e2_ff};
         for (int i = 1; i < CORDIC_LAT; i++) begin
            sb2_ff[i] <= sb2_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Back: the three velocity components
   // ------------------------------------------------------------------
   sb2_type            r1_sb_ff;
   logic signed [65:0] r1_psf_ff, r1_pcf_ff;
   logic signed [31:0] r1_omz_ff, r1_zh_ff, r1_cy_ff, r1_sy_ff;
   logic signed [31:0] r2_q1_ff, r2_q2_ff, r2_h_ff, r2_cy_ff, r2_sy_ff, r2_g_ff;
   logic signed [65:0] r2_pzz_ff;
   logic signed [65:0] r3_pq1_ff, r3_pq2_ff;
   logic signed [31:0] r3_zz_ff, r3_h_ff, r3_g_ff;
   logic signed [31:0] r4_vxp_ff, r4_q3_ff, r4_h_ff, r4_g_ff;
   logic signed [65:0] r4_pwz_ff;
   logic signed [31:0] r5_vx_ff, r5_wzz_ff, r5_h_ff;
   logic signed [65:0] r5_pq3_ff;
   logic signed [31:0] r6_vx_ff, r6_vy_ff;
   logic signed [65:0] r6_pwh_ff;
   logic signed [31:0] r7_vx_ff, r7_vy_ff, r7_vz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_psf_ff <= mul32(pa_ff, sf);
         r1_pcf_ff <= mul32(pa_ff, cf);
         r1_omz_ff <= sub_sat(ONE, sb2_ff[CORDIC_LAT-1].z);
         r1_zh_ff  <= sub_sat(sb2_ff[CORDIC_LAT-1].z, HALF);
         r1_cy_ff  <= cy;
         r1_sy_ff  <= sy;
         r1_sb_ff  <= sb2_ff[CORDIC_LAT-1];

         r2_q1_ff  <= qround(r1_psf_ff, FRAC_BITS);
         r2_q2_ff  <= qround(r1_pcf_ff, FRAC_BITS);
         r2_pzz_ff <= mul32(r1_sb_ff.z, r1_omz_ff);
         r2_h_ff   <= sub_sat(r1_zh_ff, r1_sb_ff.e2);
         r2_cy_ff  <= r1_cy_ff;
         r2_sy_ff  <= r1_sy_ff;
         r2_g_ff   <= r1_sb_ff.g;

         r3_pq1_ff <= mul32(r2_q1_ff, r2_cy_ff);
         r3_pq2_ff <= mul32(r2_q2_ff, r2_sy_ff);
         r3_zz_ff  <= qround(r2_pzz_ff, FRAC_BITS);
         r3_h_ff   <= r2_h_ff;
         r3_g_ff   <= r2_g_ff;

         r4_vxp_ff <= qround(r3_pq1_ff, FRAC_BITS);
         r4_q3_ff  <= qround(r3_pq2_ff, FRAC_BITS);
         r4_pwz_ff <= mul32(w_ff, r3_zz_ff);
         r4_h_ff   <= r3_h_ff;
         r4_g_ff   <= r3_g_ff;

         r5_vx_ff  <= sub_sat(32'sd0, r4_vxp_ff);
         r5_pq3_ff <= mul32(r4_q3_ff, r4_g_ff);
         r5_wzz_ff <= qround(r4_pwz_ff, FRAC_BITS);
         r5_h_ff   <= r4_h_ff;

         r6_vx_ff  <= r5_vx_ff;
         r6_vy_ff  <= qround(r5_pq3_ff, FRAC_BITS);
         r6_pwh_ff <= mul32(r5_wzz_ff, r5_h_ff);

         r7_vx_ff  <= r6_vx_ff;
         r7_vy_ff  <= r6_vy_ff;
         r7_vz_ff  <= qround(r6_pwh_ff, FRAC_BITS);
      end
   end

   assign rsp_vel_x = r7_vx_ff;
   assign rsp_vel_y = r7_vy_ff;
   assign rsp_vel_z = r7_vz_ff;

endmodule
`default_nettype wire

// ----- rtl/dg3v_sincos.sv -----
`default_nettype none
// ============================================================================
// dg3v_sincos - pipelined CORDIC sine and cosine
// Phase in turns (32 fraction bits) in, sine and cosine with FRAC_BITS
// fraction bits out through input, rotation and output registers; advances only when en is high.
// ============================================================================
module dg3v_sincos #(
   parameter int FRAC_BITS = dg3v_pkg::FRAC_BITS_DEF,
   parameter int STAGES    = dg3v_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic        [31:0] phase,
   output logic signed      [31:0] sin_q,
   output logic signed      [31:0] cos_q
);
   import dg3v_pkg::*;

   localparam int     SH  = 30 - FRAC_BITS;
   localparam longint RND = (SH == 0) ? 0 : (longint'(1) << ((SH > 0) ? SH - 1 : 0));

   logic signed [33:0] x_ff [STAGES+1];
   logic signed [33:0] y_ff [STAGES+1];
   logic signed [33:0] z_ff [STAGES+1];
   logic               flip_ff [STAGES+1];

   logic signed [31:0] z_raw;
   logic               flip_in;
   logic signed [31:0] z_in;
   logic signed [33:0] x_out;
   logic signed [33:0] y_out;

   // Fold the phase into a quarter turn either side of zero
   always_comb begin
      z_raw   = signed'(phase);
      flip_in = (z_raw > 32'sh4000_0000) || (z_raw < -32'sh4000_0000);
      z_in    = flip_in ? signed'(phase + 32'h8000_0000) : z_raw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= 34'(Q30_INV_GAIN);
         y_ff[0]    <= '0;
         z_ff[0]    <= 34'(z_in);
         flip_ff[0] <= flip_in;
      end
   end

   // One rotation per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [33:0] ATAN = signed'({2'b00, atan_turns(i)});
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // Undo the fold and round half up to the output format
   always_comb begin
      x_out = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      y_out = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_q <= 32'((x_out + 34'(RND)) >>> SH);
         sin_q <= 32'((y_out + 34'(RND)) >>> SH);
      end
   end

endmodule
`default_nettype wire
